/* design/rilp_pkg.sv */
// ----------------------------------------------------------------------------
// rilp_pkg
// Shared types and constants of the radix integer literal parser.
// ----------------------------------------------------------------------------
package rilp_pkg;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_DIGIT  = 3'd1;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd2;
  localparam logic [2:0] ST_BAD_SYNTAX = 3'd3;
  localparam logic [2:0] ST_OVERFLOW   = 3'd4;

  localparam logic [4:0] RADIX_BIN = 5'd2;
  localparam logic [4:0] RADIX_OCT = 5'd8;
  localparam logic [4:0] RADIX_DEC = 5'd10;
  localparam logic [4:0] RADIX_HEX = 5'd16;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_O  = 8'h6F;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  localparam logic [7:0] LETTER_BASE = 8'd10;
  localparam logic [7:0] IDX_MAX     = 8'hFF;

  typedef struct packed {
    logic       last;
    logic [7:0] char_code;
  } item_t;

  typedef struct packed {
    logic       is_dec;
    logic       is_alnum;
    logic [5:0] value;
    logic       is_minus;
    logic       is_space;
    logic       is_prefix;
    logic [4:0] prefix_radix;
  } char_class_t;

endpackage

/* design/rilp_in_if.sv */
// ----------------------------------------------------------------------------
// rilp_in_if
// Character channel: one character of a literal per transfer.
// ----------------------------------------------------------------------------
interface rilp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_literal;

  modport source (output valid, output char_code, output end_of_literal, input ready);
  modport sink   (input valid, input char_code, input end_of_literal, output ready);
endinterface

/* design/rilp_out_if.sv */
// ----------------------------------------------------------------------------
// rilp_out_if
// Result channel: one parsed literal per transfer.
// ----------------------------------------------------------------------------
interface rilp_out_if #(
  parameter int VALUE_WIDTH = 64
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] magnitude;
  logic                   negative;
  logic [2:0]             status;
  logic [7:0]             error_position;
  logic [7:0]             error_char;
  logic [4:0]             radix_used;

  modport source (output valid, output magnitude, output negative, output status,
                  output error_position, output error_char, output radix_used,
                  input ready);
  modport sink   (input valid, input magnitude, input negative, input status,
                  input error_position, input error_char, input radix_used,
                  output ready);
endinterface

/* design/radix_integer_literal_parser_top.sv */
// ----------------------------------------------------------------------------
// radix_integer_literal_parser_top
// Parses a signed integer literal with optional 0b/0o/0d/0x prefix, one
// character per transfer, and gives one result per literal.
//
//   channel     dir  payload                                     transfer
//   char_in_i   in   char_code, end_of_literal                   every char
//   result_o    out  magnitude, negative, status, error_position, last char
//                    error_char, radix_used
//
// One character per cycle while no result stalls a last character; a result
// passes the input register, then the parse state and result register.
// The per-character step is a shift-and-add by the radix with a carry check.
// Reset clears parse state and the result register; no clearing pass.
// A stalled result holds its register; the input register still takes one
// more character, and characters that end no literal keep flowing.
// ----------------------------------------------------------------------------
module radix_integer_literal_parser_top #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rilp_in_if.sink    char_in_i,
  rilp_out_if.source result_o
);

  rilp_pkg::item_t       in_item;
  rilp_pkg::item_t       item;
  rilp_pkg::char_class_t cls;
  logic                  item_valid;
  logic                  advance;

  assign in_item.char_code = char_in_i.char_code;
  assign in_item.last      = char_in_i.end_of_literal;

  rilp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (char_in_i.valid),
    .in_ready_o   (char_in_i.ready),
    .in_item_i    (in_item),
    .advance_i    (advance),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  rilp_char_decode u_decode (
    .char_code_i (item.char_code),
    .class_o     (cls)
  );

  rilp_parse_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .class_i      (cls),
    .advance_o    (advance),
    .res_o        (result_o)
  );

endmodule

/* design/rilp_in_reg.sv */
// ----------------------------------------------------------------------------
// rilp_in_reg
// Input register stage; holds one character until the parser takes it.
// ----------------------------------------------------------------------------
module rilp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rilp_pkg::item_t in_item_i,
  input  logic          advance_i,
  output logic          item_valid_o,
  output rilp_pkg::item_t item_o
);

  logic            valid_q;
  rilp_pkg::item_t item_q;

  assign in_ready_o   = !valid_q || advance_i;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      item_q  <= '0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
      item_q  <= in_item_i;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

/* design/rilp_char_decode.sv */
// ----------------------------------------------------------------------------
// rilp_char_decode
// Classifies one character: digit value, sign, space and radix prefix letter.
// ----------------------------------------------------------------------------
module rilp_char_decode (
  input  logic [7:0]              char_code_i,
  output rilp_pkg::char_class_t   class_o
);

  logic       is_dec;
  logic       is_lo;
  logic       is_up;
  logic [7:0] val8;

  assign is_dec = (char_code_i >= rilp_pkg::CH_0) && (char_code_i <= rilp_pkg::CH_9);
  assign is_lo  = (char_code_i >= rilp_pkg::CH_LO_A) && (char_code_i <= rilp_pkg::CH_LO_Z);
  assign is_up  = (char_code_i >= rilp_pkg::CH_UP_A) && (char_code_i <= rilp_pkg::CH_UP_Z);

  always_comb begin
    if (is_lo) begin
      val8 = char_code_i - rilp_pkg::CH_LO_A + rilp_pkg::LETTER_BASE;
    end else if (is_up) begin
      val8 = char_code_i - rilp_pkg::CH_UP_A + rilp_pkg::LETTER_BASE;
    end else begin
      val8 = char_code_i - rilp_pkg::CH_0;
    end
  end

  always_comb begin
    class_o.is_dec    = is_dec;
    class_o.is_alnum  = is_dec || is_lo || is_up;
    class_o.value     = val8[5:0];
    class_o.is_minus  = (char_code_i == rilp_pkg::CH_MINUS);
    class_o.is_space  = (char_code_i == rilp_pkg::CH_SPACE);
    class_o.is_prefix = 1'b1;
    case (char_code_i)
      rilp_pkg::CH_LO_B: class_o.prefix_radix = rilp_pkg::RADIX_BIN;
      rilp_pkg::CH_LO_O: class_o.prefix_radix = rilp_pkg::RADIX_OCT;
      rilp_pkg::CH_LO_D: class_o.prefix_radix = rilp_pkg::RADIX_DEC;
      rilp_pkg::CH_LO_X: class_o.prefix_radix = rilp_pkg::RADIX_HEX;
      default: begin
        class_o.is_prefix    = 1'b0;
        class_o.prefix_radix = rilp_pkg::RADIX_DEC;
      end
    endcase
  end

endmodule

/* design/rilp_parse_core.sv */
// ----------------------------------------------------------------------------
// rilp_parse_core
// Parse state, shift-and-add accumulation with overflow check, result register.
// ----------------------------------------------------------------------------
module rilp_parse_core #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  item_valid_i,
  input  rilp_pkg::item_t       item_i,
  input  rilp_pkg::char_class_t class_i,
  output logic                  advance_o,
  rilp_out_if.source            res_o
);

  localparam int EXT_W = VALUE_WIDTH + 5;

  typedef enum logic [2:0] {
    PH_START,
    PH_AFTER_SIGN,
    PH_SAW_ZERO,
    PH_PREFIX_DONE,
    PH_DIGITS,
    PH_ERROR
  } phase_e;

  phase_e                 phase_q, phase_s, phase_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_s, acc_d;
  logic [4:0]             radix_q, radix_s, radix_d;
  logic [7:0]             idx_q, idx_s, idx_d;
  logic                   sign_q, sign_s, sign_d;
  logic [2:0]             ecode_q, ecode_s, ecode_d;
  logic [7:0]             eidx_q, eidx_s, eidx_d;
  logic [7:0]             ech_q, ech_s, ech_d;

  logic                   res_valid_q;
  logic [VALUE_WIDTH-1:0] res_mag_q, res_mag_d;
  logic                   res_neg_q;
  logic [2:0]             res_status_q, res_status_d;
  logic [7:0]             res_pos_q, res_pos_d;
  logic [7:0]             res_ch_q, res_ch_d;
  logic [4:0]             res_radix_q;

  logic [EXT_W-1:0]       ext;
  logic [EXT_W-1:0]       prod;
  logic [EXT_W-1:0]       sum;
  logic                   ovf;
  logic                   feed_err;
  logic [2:0]             feed_code;
  logic                   take_first;
  logic                   take_feed;
  logic                   step_en;

  assign advance_o = !item_i.last || !res_valid_q || res_o.ready;
  assign step_en   = item_valid_i && advance_o;

  assign ext = {5'b0, acc_q};

  always_comb begin
    case (radix_q)
      rilp_pkg::RADIX_BIN: prod = ext << 1;
      rilp_pkg::RADIX_OCT: prod = ext << 3;
      rilp_pkg::RADIX_HEX: prod = ext << 4;
      default:             prod = (ext << 3) + (ext << 1);
    endcase
  end

  assign sum = prod + EXT_W'(class_i.value);
  assign ovf = |sum[EXT_W-1:VALUE_WIDTH];

  always_comb begin
    feed_err  = 1'b1;
    feed_code = rilp_pkg::ST_OK;
    if (!class_i.is_alnum) begin
      feed_code = rilp_pkg::ST_BAD_SYNTAX;
    end else if (class_i.value >= {1'b0, radix_q}) begin
      feed_code = rilp_pkg::ST_BAD_DIGIT;
    end else if (ovf) begin
      feed_code = rilp_pkg::ST_OVERFLOW;
    end else begin
      feed_err = 1'b0;
    end
  end

  always_comb begin
    phase_s    = phase_q;
    acc_s      = acc_q;
    radix_s    = radix_q;
    idx_s      = idx_q;
    sign_s     = sign_q;
    ecode_s    = ecode_q;
    eidx_s     = eidx_q;
    ech_s      = ech_q;
    take_first = 1'b0;
    take_feed  = 1'b0;

    unique case (phase_q)
      PH_START: begin
        if (class_i.is_minus) begin
          sign_s  = 1'b1;
          phase_s = PH_AFTER_SIGN;
        end else begin
          take_first = 1'b1;
        end
      end
      PH_AFTER_SIGN: begin
        take_first = !class_i.is_space;
      end
      PH_SAW_ZERO: begin
        if (class_i.is_prefix) begin
          radix_s = class_i.prefix_radix;
          acc_s   = '0;
          idx_s   = '0;
          phase_s = PH_PREFIX_DONE;
        end else begin
          take_feed = 1'b1;
        end
      end
      PH_PREFIX_DONE, PH_DIGITS: begin
        take_feed = 1'b1;
      end
      default: ;
    endcase

    if (take_first) begin
      if (class_i.is_dec) begin
        take_feed = 1'b1;
      end else begin
        ecode_s = rilp_pkg::ST_BAD_PREFIX;
        eidx_s  = '0;
        ech_s   = '0;
        phase_s = PH_ERROR;
      end
    end

    if (take_feed) begin
      if (feed_err) begin
        ecode_s = feed_code;
        eidx_s  = idx_q;
        ech_s   = item_i.char_code;
        phase_s = PH_ERROR;
      end else begin
        acc_s   = sum[VALUE_WIDTH-1:0];
        idx_s   = (idx_q == rilp_pkg::IDX_MAX) ? idx_q : idx_q + 8'd1;
        phase_s = PH_DIGITS;
      end
    end

    // a leading zero that may start a radix prefix
    if (take_first && class_i.is_dec && class_i.value == '0) begin
      phase_s = PH_SAW_ZERO;
    end
  end

  always_comb begin
    res_status_d = rilp_pkg::ST_OK;
    res_pos_d    = '0;
    res_ch_d     = '0;
    res_mag_d    = acc_s;
    if (phase_s == PH_START || phase_s == PH_AFTER_SIGN) begin
      res_status_d = rilp_pkg::ST_BAD_PREFIX;
      res_mag_d    = '0;
    end else if (phase_s == PH_PREFIX_DONE) begin
      res_status_d = rilp_pkg::ST_BAD_SYNTAX;
      res_mag_d    = '0;
    end else if (phase_s == PH_ERROR) begin
      res_status_d = ecode_s;
      res_pos_d    = eidx_s;
      res_ch_d     = ech_s;
      res_mag_d    = '0;
    end

    if (item_i.last) begin
      phase_d = PH_START;
      acc_d   = '0;
      radix_d = rilp_pkg::RADIX_DEC;
      idx_d   = '0;
      sign_d  = 1'b0;
      ecode_d = rilp_pkg::ST_OK;
      eidx_d  = '0;
      ech_d   = '0;
    end else begin
      phase_d = phase_s;
      acc_d   = acc_s;
      radix_d = radix_s;
      idx_d   = idx_s;
      sign_d  = sign_s;
      ecode_d = ecode_s;
      eidx_d  = eidx_s;
      ech_d   = ech_s;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_START;
      acc_q        <= '0;
      radix_q      <= rilp_pkg::RADIX_DEC;
      idx_q        <= '0;
      sign_q       <= 1'b0;
      ecode_q      <= rilp_pkg::ST_OK;
      eidx_q       <= '0;
      ech_q        <= '0;
      res_valid_q  <= 1'b0;
      res_mag_q    <= '0;
      res_neg_q    <= 1'b0;
      res_status_q <= rilp_pkg::ST_OK;
      res_pos_q    <= '0;
      res_ch_q     <= '0;
      res_radix_q  <= rilp_pkg::RADIX_DEC;
    end else begin
      if (step_en) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        radix_q <= radix_d;
        idx_q   <= idx_d;
        sign_q  <= sign_d;
        ecode_q <= ecode_d;
        eidx_q  <= eidx_d;
        ech_q   <= ech_d;
      end
      if (step_en && item_i.last) begin
        res_valid_q  <= 1'b1;
        res_mag_q    <= res_mag_d;
        res_neg_q    <= sign_s;
        res_status_q <= res_status_d;
        res_pos_q    <= res_pos_d;
        res_ch_q     <= res_ch_d;
        res_radix_q  <= radix_s;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.magnitude      = res_mag_q;
  assign res_o.negative       = res_neg_q;
  assign res_o.status         = res_status_q;
  assign res_o.error_position = res_pos_q;
  assign res_o.error_char     = res_ch_q;
  assign res_o.radix_used     = res_radix_q;

endmodule

/* design/rilp_checker.sv */
// ----------------------------------------------------------------------------
// rilp_checker
// Port-level checks on the result channel of the literal parser.
// ----------------------------------------------------------------------------
module rilp_checker #(
  parameter int VALUE_WIDTH = 64
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [VALUE_WIDTH-1:0] magnitude_i,
  input logic [2:0]             status_i,
  input logic [7:0]             error_position_i,
  input logic [7:0]             error_char_i,
  input logic [4:0]             radix_used_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_hold_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(magnitude_i) && $stable(status_i)
                                    && $stable(error_position_i) && $stable(error_char_i))
    else $error("result changed while stalled");

  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == rilp_pkg::ST_OK
      |-> error_position_i == 8'd0 && error_char_i == 8'd0)
    else $error("error fields set on ok result");

  a_err_zero_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != rilp_pkg::ST_OK |-> magnitude_i == '0)
    else $error("magnitude nonzero on failed literal");

  a_radix_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> radix_used_i == rilp_pkg::RADIX_BIN
                 || radix_used_i == rilp_pkg::RADIX_OCT
                 || radix_used_i == rilp_pkg::RADIX_DEC
                 || radix_used_i == rilp_pkg::RADIX_HEX)
    else $error("illegal radix reported");

endmodule

bind radix_integer_literal_parser_top rilp_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_rilp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_i      (result_o.valid),
  .out_ready_i      (result_o.ready),
  .magnitude_i      (result_o.magnitude),
  .status_i         (result_o.status),
  .error_position_i (result_o.error_position),
  .error_char_i     (result_o.error_char),
  .radix_used_i     (result_o.radix_used)
);
